>>> hdl/vt52s_pkg.sv
// Shared types and constants for the VT52 terminal screen engine.
package vt52s_pkg;

    localparam int CW = 7;
    localparam int RW = 5;

    localparam logic [2:0] CMD_CHAR_ATTR = 3'd0;
    localparam logic [2:0] CMD_ATTR      = 3'd1;
    localparam logic [2:0] CMD_CHAR      = 3'd2;
    localparam logic [2:0] CMD_FILL      = 3'd3;
    localparam logic [2:0] CMD_MOVE      = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;
    localparam logic [2:0] CMD_BELL      = 3'd6;
    localparam logic [2:0] CMD_NONE      = 3'd7;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_YROW = 3'd2;
    localparam logic [2:0] MODE_YCOL = 3'd3;
    localparam logic [2:0] MODE_CSI  = 3'd4;

    localparam logic [7:0] ATTR_REV   = 8'hFF;
    localparam logic [7:0] GLYPH_SPACE = 8'd32;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]    command;
        logic [CW-1:0] column;
        logic [RW-1:0] row;
        logic [7:0]    glyph;
        logic [7:0]    attribute;
        logic [CW-1:0] span;
        logic [RW-1:0] dest_row;
        logic [CW-1:0] cursor_col;
        logic [RW-1:0] cursor_row;
        logic          last;
    } out_beat_t;

    typedef struct packed {
        logic          attr_en;
        logic [CW-1:0] attr_col;
        logic [RW-1:0] attr_row;
        logic [7:0]    attr_val;
        logic          main_en;
        logic [2:0]    main_cmd;
        logic [CW-1:0] main_col;
        logic [RW-1:0] main_row;
        logic [7:0]    main_glyph;
        logic [7:0]    main_attr;
        logic [CW-1:0] main_span;
        logic          move_en;
        logic [RW-1:0] move_src;
        logic [CW-1:0] move_span;
        logic [RW-1:0] move_dst;
        logic          fill_en;
        logic [CW-1:0] fill_col;
        logic [RW-1:0] fill_row;
        logic [CW-1:0] fill_len;
        logic          rows_en;
        logic [RW-1:0] rows_first;
        logic [CW-1:0] cur_col;
        logic [RW-1:0] cur_row;
    } plan_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_EMIT
    } seq_state_t;

endpackage

>>> hdl/vt52s_parser.sv
// Parser state, cursor state and per-item command plan.
module vt52s_parser #(
    parameter int COLS = 80,
    parameter int ROWS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  logic                take,
    input  vt52s_pkg::in_beat_t beat,
    output vt52s_pkg::plan_t    plan
);
    localparam int CW = vt52s_pkg::CW;
    localparam int RW = vt52s_pkg::RW;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [CW-1:0] NCOLS    = CW'(COLS);

    logic [15:0]   period_reg;
    logic [CW-1:0] col_reg, col_next, scol_reg, scol_next;
    logic [RW-1:0] row_reg, row_next, srow_reg, srow_next;
    logic [RW-1:0] top_reg, top_next, bot_reg, bot_next;
    logic          rev_reg, rev_next, vis_reg, vis_next;
    logic [15:0]   elap_reg, elap_next;
    logic [2:0]    mode_reg, mode_next;
    logic [7:0]    prow_reg, prow_next;
    logic [7:0]    csi_reg [4];
    logic [7:0]    csi_next [4];
    logic [1:0]    idx_reg, idx_next;
    vt52s_pkg::plan_t plan_reg, plan_next;

    logic [7:0] ch, p0, p1, n, h, v, tab;
    logic [8:0] s9;
    logic       hide_req, ld_req, esc_go, erase_end, erase_line;

    function automatic logic [RW-1:0] clamp_r(input logic [8:0] x);
        clamp_r = (x > 9'(ROWS - 1)) ? LAST_ROW : x[RW-1:0];
    endfunction

    function automatic logic [CW-1:0] clamp_c(input logic [8:0] x);
        clamp_c = (x > 9'(COLS - 1)) ? LAST_COL : x[CW-1:0];
    endfunction

    always_comb begin
        col_next  = col_reg;   row_next  = row_reg;
        scol_next = scol_reg;  srow_next = srow_reg;
        top_next  = top_reg;   bot_next  = bot_reg;
        rev_next  = rev_reg;   vis_next  = vis_reg;
        elap_next = elap_reg;  mode_next = mode_reg;
        prow_next = prow_reg;  idx_next  = idx_reg;
        for (int i = 0; i < 4; i++) csi_next[i] = csi_reg[i];
        plan_next = '0;
        plan_next.attr_col = col_reg;
        plan_next.attr_row = row_reg;
        plan_next.attr_val = rev_reg ? vt52s_pkg::ATTR_REV : 8'd0;
        hide_req   = 1'b0;
        ld_req     = 1'b0;
        esc_go     = 1'b0;
        erase_end  = 1'b0;
        erase_line = 1'b0;
        ch  = beat.data_byte;
        p0  = csi_reg[0];
        p1  = csi_reg[1];
        n   = (p0 == 8'd0) ? 8'd1 : p0;
        h   = 8'd0;
        v   = 8'd0;
        s9  = 9'd0;
        tab = {1'b0, col_reg & 7'b1111000} + 8'd8;

        if (beat.action) begin
            if (elap_reg != 16'hFFFF) elap_next = elap_reg + 16'd1;
            if (elap_next >= period_reg) begin
                elap_next = 16'd0;
                plan_next.attr_en = 1'b1;
                if (!vis_reg) plan_next.attr_val = vt52s_pkg::ATTR_REV;
                vis_next = !vis_reg;
            end
        end else begin
            case (mode_reg)
                vt52s_pkg::MODE_ESC: begin
                    hide_req  = 1'b1;
                    esc_go    = 1'b1;
                    mode_next = vt52s_pkg::MODE_IDLE;
                end
                vt52s_pkg::MODE_YROW: begin
                    prow_next = ch - 8'd32;
                    mode_next = vt52s_pkg::MODE_YCOL;
                end
                vt52s_pkg::MODE_YCOL: begin
                    row_next  = clamp_r({1'b0, prow_reg});
                    col_next  = clamp_c({1'b0, ch - 8'd32});
                    mode_next = vt52s_pkg::MODE_IDLE;
                end
                vt52s_pkg::MODE_CSI: begin
                    if (ch >= "0" && ch <= "9") begin
                        v = csi_reg[idx_reg];
                        csi_next[idx_reg] = (v << 3) + (v << 1) + (ch - "0");
                    end else if (ch == ";") begin
                        if (idx_reg != 2'd3) idx_next = idx_reg + 2'd1;
                    end else if (ch != "?") begin
                        mode_next = vt52s_pkg::MODE_IDLE;
                        case (ch)
                            "A": row_next = (n >= {3'd0, row_reg}) ? '0 : row_reg - n[RW-1:0];
                            "B": begin
                                s9 = {4'd0, row_reg} + {1'b0, n};
                                row_next = clamp_r(s9);
                            end
                            "C": begin
                                s9 = {2'd0, col_reg} + {1'b0, n};
                                col_next = clamp_c(s9);
                            end
                            "D": col_next = (n >= {1'b0, col_reg}) ? '0 : col_reg - n[CW-1:0];
                            "H", "f": begin
                                h = (p0 == 8'd0) ? 8'd0 : p0 - 8'd1;
                                row_next = clamp_r({1'b0, h});
                                v = (idx_reg != 2'd0 && p1 != 8'd0) ? p1 - 8'd1 : 8'd0;
                                col_next = clamp_c({1'b0, v});
                            end
                            "J": begin
                                if (p0 == 8'd2) begin
                                    plan_next.main_en    = 1'b1;
                                    plan_next.main_cmd   = vt52s_pkg::CMD_CLEAR;
                                    plan_next.main_glyph = vt52s_pkg::GLYPH_SPACE;
                                    vis_next = 1'b0;
                                    col_next = '0;
                                    row_next = '0;
                                end else begin
                                    erase_end = 1'b1;
                                end
                            end
                            "K": erase_line = 1'b1;
                            "r": begin
                                h = (p0 == 8'd0) ? 8'd0 : p0 - 8'd1;
                                top_next = clamp_r({1'b0, h});
                                v = (idx_reg != 2'd0 && p1 != 8'd0) ? p1 - 8'd1 : 8'(ROWS - 1);
                                bot_next = clamp_r({1'b0, v});
                                if (bot_next < top_next) bot_next = top_next;
                            end
                            "m": begin
                                if (p0 == 8'd0) rev_next = 1'b0;
                                else if (p0 == 8'd7) rev_next = 1'b1;
                            end
                            "s": begin
                                scol_next = col_reg;
                                srow_next = row_reg;
                            end
                            "u": begin
                                col_next = clamp_c({2'd0, scol_reg});
                                row_next = clamp_r({4'd0, srow_reg});
                            end
                            default: ;
                        endcase
                    end
                end
                default: begin
                    mode_next = vt52s_pkg::MODE_IDLE;
                    case (ch)
                        8'd27: mode_next = vt52s_pkg::MODE_ESC;
                        8'd13: begin
                            hide_req = 1'b1;
                            col_next = '0;
                        end
                        8'd10, 8'd11: begin
                            hide_req = 1'b1;
                            ld_req   = 1'b1;
                        end
                        8'd12: begin
                            plan_next.main_en    = 1'b1;
                            plan_next.main_cmd   = vt52s_pkg::CMD_CLEAR;
                            plan_next.main_glyph = vt52s_pkg::GLYPH_SPACE;
                            vis_next = 1'b0;
                            col_next = '0;
                            row_next = '0;
                        end
                        8'd7: begin
                            plan_next.main_en  = 1'b1;
                            plan_next.main_cmd = vt52s_pkg::CMD_BELL;
                        end
                        8'd8, 8'd127: begin
                            hide_req = 1'b1;
                            if (col_reg != '0) begin
                                col_next = col_reg - CW'(1);
                                plan_next.main_en    = 1'b1;
                                plan_next.main_cmd   = vt52s_pkg::CMD_CHAR;
                                plan_next.main_col   = col_reg - CW'(1);
                                plan_next.main_row   = row_reg;
                                plan_next.main_glyph = vt52s_pkg::GLYPH_SPACE;
                                plan_next.main_span  = CW'(1);
                            end
                        end
                        8'd9: col_next = clamp_c({1'b0, tab});
                        default: begin
                            if (ch >= 8'd32) begin
                                hide_req = 1'b1;
                                plan_next.main_en    = 1'b1;
                                plan_next.main_cmd   = vt52s_pkg::CMD_CHAR_ATTR;
                                plan_next.main_col   = col_reg;
                                plan_next.main_row   = row_reg;
                                plan_next.main_glyph = ch;
                                plan_next.main_attr  = plan_next.attr_val;
                                plan_next.main_span  = CW'(1);
                                if (col_reg == LAST_COL) begin
                                    col_next = '0;
                                    ld_req   = 1'b1;
                                end else begin
                                    col_next = col_reg + CW'(1);
                                end
                            end
                        end
                    endcase
                end
            endcase
        end

        if (hide_req && vis_reg) begin
            plan_next.attr_en = 1'b1;
            vis_next = 1'b0;
        end

        if (esc_go) begin
            case (ch)
                "A": if (row_reg != '0) row_next = row_reg - RW'(1);
                "B": if (row_reg < LAST_ROW) row_next = row_reg + RW'(1);
                "C": if (col_reg < LAST_COL) col_next = col_reg + CW'(1);
                "D": if (col_reg != '0) col_next = col_reg - CW'(1);
                "H": begin
                    col_next = '0;
                    row_next = '0;
                end
                "E": begin
                    plan_next.main_en    = 1'b1;
                    plan_next.main_cmd   = vt52s_pkg::CMD_CLEAR;
                    plan_next.main_glyph = vt52s_pkg::GLYPH_SPACE;
                    vis_next = 1'b0;
                    col_next = '0;
                    row_next = '0;
                end
                "I": begin
                    if (row_reg > top_reg) begin
                        row_next = row_reg - RW'(1);
                    end else begin
                        plan_next.move_en   = bot_reg > top_reg;
                        plan_next.move_src  = top_reg;
                        plan_next.move_span = CW'(bot_reg - top_reg);
                        plan_next.move_dst  = top_reg + RW'(1);
                        plan_next.fill_en   = 1'b1;
                        plan_next.fill_row  = top_reg;
                        plan_next.fill_len  = NCOLS;
                    end
                end
                "J": erase_end = 1'b1;
                "K": erase_line = 1'b1;
                "Y": mode_next = vt52s_pkg::MODE_YROW;
                "7": begin
                    scol_next = col_reg;
                    srow_next = row_reg;
                end
                "8": begin
                    col_next = clamp_c({2'd0, scol_reg});
                    row_next = clamp_r({4'd0, srow_reg});
                end
                "[": begin
                    for (int i = 0; i < 4; i++) csi_next[i] = 8'd0;
                    idx_next  = 2'd0;
                    mode_next = vt52s_pkg::MODE_CSI;
                end
                default: ;
            endcase
        end

        if (erase_end || erase_line) begin
            plan_next.fill_en  = 1'b1;
            plan_next.fill_col = col_reg;
            plan_next.fill_row = row_reg;
            plan_next.fill_len = NCOLS - col_reg;
        end
        if (erase_end) begin
            plan_next.rows_en    = row_reg < LAST_ROW;
            plan_next.rows_first = row_reg + RW'(1);
        end

        if (ld_req) begin
            if (row_reg == bot_reg) begin
                plan_next.move_en   = bot_reg > top_reg;
                plan_next.move_src  = top_reg + RW'(1);
                plan_next.move_span = CW'(bot_reg - top_reg);
                plan_next.move_dst  = top_reg;
                plan_next.fill_en   = 1'b1;
                plan_next.fill_row  = bot_reg;
                plan_next.fill_len  = NCOLS;
            end else if (row_reg < LAST_ROW) begin
                row_next = row_reg + RW'(1);
            end
        end

        plan_next.cur_col = col_next;
        plan_next.cur_row = row_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= 16'd500;
            col_reg  <= '0;  row_reg  <= '0;
            scol_reg <= '0;  srow_reg <= '0;
            top_reg  <= '0;  bot_reg  <= LAST_ROW;
            rev_reg  <= 1'b0; vis_reg <= 1'b0;
            elap_reg <= '0;  mode_reg <= vt52s_pkg::MODE_IDLE;
            prow_reg <= '0;  idx_reg  <= '0;
            for (int i = 0; i < 4; i++) csi_reg[i] <= '0;
        end else begin
            if (cfg_we) period_reg <= cfg_data;
            if (take) begin
                col_reg  <= col_next;  row_reg  <= row_next;
                scol_reg <= scol_next; srow_reg <= srow_next;
                top_reg  <= top_next;  bot_reg  <= bot_next;
                rev_reg  <= rev_next;  vis_reg  <= vis_next;
                elap_reg <= elap_next; mode_reg <= mode_next;
                prow_reg <= prow_next; idx_reg  <= idx_next;
                for (int i = 0; i < 4; i++) csi_reg[i] <= csi_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) plan_reg <= plan_next;
    end

    assign plan = plan_reg;

endmodule

>>> hdl/vt52s_emitter.sv
// Sequencer that walks a command plan and drives the result register.
module vt52s_emitter #(
    parameter int COLS = 80,
    parameter int ROWS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  vt52s_pkg::plan_t     plan,
    output logic                 idle,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vt52s_pkg::out_beat_t m_data
);
    localparam int CW = vt52s_pkg::CW;
    localparam int RW = vt52s_pkg::RW;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    localparam int F_ATTR = 0;
    localparam int F_MAIN = 1;
    localparam int F_MOVE = 2;
    localparam int F_FILL = 3;
    localparam int F_ROWS = 4;
    localparam int F_NOOP = 5;

    vt52s_pkg::seq_state_t state_reg, state_next;
    logic [5:0]            flags_reg, flags_next, flags_load, flags_left;
    logic [RW-1:0]         cnt_reg, cnt_next;
    logic                  mv_reg, mv_next, load;
    vt52s_pkg::out_beat_t  data_reg, data_next, beat;

    always_comb begin
        flags_load = {1'b0, plan.rows_en, plan.fill_en, plan.move_en,
                      plan.main_en, plan.attr_en};
        flags_load[F_NOOP] = (flags_load == 6'd0);
    end

    always_comb begin
        beat = '0;
        beat.cursor_col = plan.cur_col;
        beat.cursor_row = plan.cur_row;
        flags_left = flags_reg;
        if (flags_reg[F_ATTR]) begin
            beat.command   = vt52s_pkg::CMD_ATTR;
            beat.column    = plan.attr_col;
            beat.row       = plan.attr_row;
            beat.attribute = plan.attr_val;
            beat.span      = CW'(1);
            flags_left[F_ATTR] = 1'b0;
        end else if (flags_reg[F_MAIN]) begin
            beat.command   = plan.main_cmd;
            beat.column    = plan.main_col;
            beat.row       = plan.main_row;
            beat.glyph     = plan.main_glyph;
            beat.attribute = plan.main_attr;
            beat.span      = plan.main_span;
            flags_left[F_MAIN] = 1'b0;
        end else if (flags_reg[F_MOVE]) begin
            beat.command  = vt52s_pkg::CMD_MOVE;
            beat.row      = plan.move_src;
            beat.span     = plan.move_span;
            beat.dest_row = plan.move_dst;
            flags_left[F_MOVE] = 1'b0;
        end else if (flags_reg[F_FILL]) begin
            beat.command = vt52s_pkg::CMD_FILL;
            beat.column  = plan.fill_col;
            beat.row     = plan.fill_row;
            beat.glyph   = vt52s_pkg::GLYPH_SPACE;
            beat.span    = plan.fill_len;
            flags_left[F_FILL] = 1'b0;
        end else if (flags_reg[F_ROWS]) begin
            beat.command = vt52s_pkg::CMD_FILL;
            beat.row     = cnt_reg;
            beat.glyph   = vt52s_pkg::GLYPH_SPACE;
            beat.span    = CW'(COLS);
            if (cnt_reg == LAST_ROW) flags_left[F_ROWS] = 1'b0;
        end else begin
            beat.command = vt52s_pkg::CMD_NONE;
            flags_left[F_NOOP] = 1'b0;
        end
        beat.last = (flags_left == 6'd0);
    end

    assign load = (state_reg == vt52s_pkg::SEQ_EMIT) && (!mv_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vt52s_pkg::SEQ_IDLE: if (take) state_next = vt52s_pkg::SEQ_LOAD;
            vt52s_pkg::SEQ_LOAD: state_next = vt52s_pkg::SEQ_EMIT;
            vt52s_pkg::SEQ_EMIT: if (load && beat.last) state_next = vt52s_pkg::SEQ_IDLE;
            default: state_next = vt52s_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        flags_next = flags_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        data_next  = data_reg;
        case (state_reg)
            vt52s_pkg::SEQ_LOAD: begin
                flags_next = flags_load;
                cnt_next   = plan.rows_first;
            end
            vt52s_pkg::SEQ_EMIT: begin
                if (load) begin
                    flags_next = flags_left;
                    mv_next    = 1'b1;
                    data_next  = beat;
                    if (!flags_reg[F_ATTR] && !flags_reg[F_MAIN] && !flags_reg[F_MOVE]
                        && !flags_reg[F_FILL] && flags_reg[F_ROWS]) begin
                        cnt_next = cnt_reg + RW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vt52s_pkg::SEQ_IDLE;
            flags_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        data_reg <= data_next;
    end

    assign idle    = (state_reg == vt52s_pkg::SEQ_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = data_reg;

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vt52s_pkg::SEQ_IDLE) |-> (flags_reg == 6'd0))
        else $error("flags left while idle");
    a_load_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vt52s_pkg::SEQ_LOAD) |=> (state_reg == vt52s_pkg::SEQ_EMIT))
        else $error("load not followed by emit");
    a_rows_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flags_reg[F_ROWS] |-> (cnt_reg <= LAST_ROW))
        else $error("row fill counter out of range");
    a_emit_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vt52s_pkg::SEQ_EMIT) |-> (flags_reg != 6'd0))
        else $error("emit with nothing pending");

endmodule

>>> hdl/vt52_terminal_screen_engine.sv
// Top level of the VT52 terminal screen engine.
// Flow: on accept the parser registers the plan and the sequencer enters SEQ_LOAD, then
// SEQ_EMIT; an item gives 1 to ROWS+1 result beats, sent one per cycle while m_ready is
// high, and no new item is accepted until the sequencer is idle again.
// Reset: synchronous active-low aresetn clears the cursor, parser, region and blink
// state and sets the blink period (period_reg) to 500 action beats; no clearing pass.
module vt52_terminal_screen_engine #(
    parameter int COLS = 80,
    parameter int ROWS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vt52s_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vt52s_pkg::out_beat_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    vt52s_pkg::plan_t plan;
    logic             idle, take;

    assign s_ready   = idle;
    assign take      = s_valid && idle;
    assign cfg_ready = 1'b1;

    vt52s_parser #(.COLS(COLS), .ROWS(ROWS)) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .take     (take),
        .beat     (s_data),
        .plan     (plan)
    );

    vt52s_emitter #(.COLS(COLS), .ROWS(ROWS)) u_emitter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .plan    (plan),
        .idle    (idle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> tb/sv/tb_vt52_terminal_screen_engine.sv
// Self-checking testbench for the VT52 terminal screen engine: escapes, CSI and random streams.
module tb_vt52_terminal_screen_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 80;
    localparam int ROWS = 24;
    localparam int LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    vt52s_pkg::in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    vt52s_pkg::out_beat_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = '0;

    vt52_terminal_screen_engine #(.COLS(COLS), .ROWS(ROWS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // terminal state mirror
    int t_period;
    int t_col, t_scol;
    int t_row, t_srow, t_top, t_bot;
    bit t_rev, t_vis;
    int t_elapsed;
    logic [2:0] t_mode;
    int t_prow;
    int t_par [4];
    int t_pidx;

    vt52s_pkg::out_beat_t screen_cmds_q [$];
    vt52s_pkg::out_beat_t item_cmds [$];
    int mismatches = 0;
    int beats_seen = 0;
    int items_sent = 0;
    bit quiet = 1'b0;

    function automatic int clampv(int v, int mx);
        return (v > mx) ? mx : v;
    endfunction

    function automatic void put(logic [2:0] c, int col, int row, logic [7:0] g,
                                logic [7:0] a, int span, int dst);
        vt52s_pkg::out_beat_t b;
        b = '0;
        b.command = c; b.column = col[6:0]; b.row = row[4:0]; b.glyph = g;
        b.attribute = a; b.span = span[6:0]; b.dest_row = dst[4:0];
        item_cmds.push_back(b);
    endfunction

    function automatic logic [7:0] cur_attr();
        return t_rev ? vt52s_pkg::ATTR_REV : 8'h00;
    endfunction

    function automatic void hide_cur();
        if (t_vis) begin
            put(vt52s_pkg::CMD_ATTR, t_col, t_row, 8'd0, cur_attr(), 1, 0);
            t_vis = 1'b0;
        end
    endfunction

    function automatic void fill(int col, int row, int len);
        put(vt52s_pkg::CMD_FILL, col, row, vt52s_pkg::GLYPH_SPACE, 8'd0, len, 0);
    endfunction

    function automatic void shift_region_up();
        if (t_bot > t_top)
            put(vt52s_pkg::CMD_MOVE, 0, t_top + 1, 8'd0, 8'd0, t_bot - t_top, t_top);
        fill(0, t_bot, COLS);
    endfunction

    function automatic void shift_region_down();
        if (t_bot > t_top)
            put(vt52s_pkg::CMD_MOVE, 0, t_top, 8'd0, 8'd0, t_bot - t_top, t_top + 1);
        fill(0, t_top, COLS);
    endfunction

    function automatic void line_feed();
        if (t_row == t_bot) shift_region_up();
        else if (t_row < ROWS - 1) t_row++;
    endfunction

    function automatic void wipe_to_eol();
        if (t_col < COLS) fill(t_col, t_row, COLS - t_col);
    endfunction

    function automatic void wipe_to_eos();
        wipe_to_eol();
        for (int r = t_row + 1; r < ROWS; r++) fill(0, r, COLS);
    endfunction

    function automatic void wipe_screen();
        put(vt52s_pkg::CMD_CLEAR, 0, 0, vt52s_pkg::GLYPH_SPACE, 8'd0, 0, 0);
        t_vis = 1'b0;
        t_col = 0;
        t_row = 0;
    endfunction

    function automatic void csi_end(int ch);
        int p0, p1, n;
        p0 = t_par[0];
        p1 = t_par[1];
        n = (p0 != 0) ? p0 : 1;
        t_mode = vt52s_pkg::MODE_IDLE;
        case (ch)
            "A": t_row = (n >= t_row) ? 0 : t_row - n;
            "B": t_row = clampv(t_row + n, ROWS - 1);
            "C": t_col = clampv(t_col + n, COLS - 1);
            "D": t_col = (n >= t_col) ? 0 : t_col - n;
            "H", "f": begin
                t_row = clampv((p0 != 0) ? p0 - 1 : 0, ROWS - 1);
                t_col = clampv((t_pidx >= 1 && p1 != 0) ? p1 - 1 : 0, COLS - 1);
            end
            "J": begin
                if (p0 == 2) wipe_screen();
                else wipe_to_eos();
            end
            "K": wipe_to_eol();
            "r": begin
                t_top = clampv((p0 != 0) ? p0 - 1 : 0, ROWS - 1);
                t_bot = clampv((t_pidx >= 1 && p1 != 0) ? p1 - 1 : ROWS - 1, ROWS - 1);
                if (t_bot < t_top) t_bot = t_top;
            end
            "m": begin
                if (p0 == 0) t_rev = 1'b0;
                else if (p0 == 7) t_rev = 1'b1;
            end
            "s": begin t_scol = t_col; t_srow = t_row; end
            "u": begin
                t_col = clampv(t_scol, COLS - 1);
                t_row = clampv(t_srow, ROWS - 1);
            end
            default: ;
        endcase
    endfunction

    function automatic void esc_end(int ch);
        t_mode = vt52s_pkg::MODE_IDLE;
        case (ch)
            "A": if (t_row > 0) t_row--;
            "B": if (t_row < ROWS - 1) t_row++;
            "C": if (t_col < COLS - 1) t_col++;
            "D": if (t_col > 0) t_col--;
            "H": begin t_col = 0; t_row = 0; end
            "E": wipe_screen();
            "I": begin
                if (t_row > t_top) t_row--;
                else shift_region_down();
            end
            "J": wipe_to_eos();
            "K": wipe_to_eol();
            "Y": t_mode = vt52s_pkg::MODE_YROW;
            "7": begin t_scol = t_col; t_srow = t_row; end
            "8": begin
                t_col = clampv(t_scol, COLS - 1);
                t_row = clampv(t_srow, ROWS - 1);
            end
            "[": begin
                for (int i = 0; i < 4; i++) t_par[i] = 0;
                t_pidx = 0;
                t_mode = vt52s_pkg::MODE_CSI;
            end
            default: ;
        endcase
    endfunction

    function automatic void term_byte(int ch);
        case (t_mode)
            vt52s_pkg::MODE_ESC: begin hide_cur(); esc_end(ch); return; end
            vt52s_pkg::MODE_YROW: begin
                t_prow = (ch - 32) & 255;
                t_mode = vt52s_pkg::MODE_YCOL;
                return;
            end
            vt52s_pkg::MODE_YCOL: begin
                t_row = clampv(t_prow, ROWS - 1);
                t_col = clampv((ch - 32) & 255, COLS - 1);
                t_mode = vt52s_pkg::MODE_IDLE;
                return;
            end
            vt52s_pkg::MODE_CSI: begin
                if (ch >= "0" && ch <= "9")
                    t_par[t_pidx] = (t_par[t_pidx] * 10 + ch - 48) & 255;
                else if (ch == ";") begin
                    if (t_pidx < 3) t_pidx++;
                end else if (ch != "?") csi_end(ch);
                return;
            end
            default: t_mode = vt52s_pkg::MODE_IDLE;
        endcase
        case (ch)
            27: t_mode = vt52s_pkg::MODE_ESC;
            13: begin hide_cur(); t_col = 0; end
            10, 11: begin hide_cur(); line_feed(); end
            12: wipe_screen();
            7: put(vt52s_pkg::CMD_BELL, 0, 0, 8'd0, 8'd0, 0, 0);
            8, 127: begin
                hide_cur();
                if (t_col > 0) begin
                    t_col--;
                    put(vt52s_pkg::CMD_CHAR, t_col, t_row, vt52s_pkg::GLYPH_SPACE, 8'd0, 1, 0);
                end
            end
            9: t_col = clampv((t_col & 'h78) + 8, COLS - 1);
            default: begin
                if (ch >= 32) begin
                    hide_cur();
                    put(vt52s_pkg::CMD_CHAR_ATTR, t_col, t_row, ch[7:0], cur_attr(), 1, 0);
                    t_col++;
                    if (t_col >= COLS) begin t_col = 0; line_feed(); end
                end
            end
        endcase
    endfunction

    function automatic void predict_item(vt52s_pkg::in_beat_t it);
        item_cmds.delete();
        if (it.action) begin
            if (t_elapsed != 'hFFFF) t_elapsed++;
            if (t_elapsed >= t_period) begin
                t_elapsed = 0;
                if (t_vis) hide_cur();
                else begin
                    put(vt52s_pkg::CMD_ATTR, t_col, t_row, 8'd0, vt52s_pkg::ATTR_REV, 1, 0);
                    t_vis = 1'b1;
                end
            end
        end else term_byte(int'(it.data_byte));
        if (item_cmds.size() == 0) put(vt52s_pkg::CMD_NONE, 0, 0, 8'd0, 8'd0, 0, 0);
        foreach (item_cmds[k]) begin
            item_cmds[k].cursor_col = 7'(t_col);
            item_cmds[k].cursor_row = 5'(t_row);
            item_cmds[k].last = (k == item_cmds.size() - 1);
            screen_cmds_q.push_back(item_cmds[k]);
        end
    endfunction

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic send_item(bit tick, logic [7:0] b);
        vt52s_pkg::in_beat_t it;
        idle_gap();
        it.action = tick;
        it.data_byte = b;
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(it);
        items_sent++;
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (screen_cmds_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_period(logic [15:0] p);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= p;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        t_period = int'(p);
        @(posedge aclk);
    endtask

    // result side: random stalls, check in order
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (screen_cmds_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", m_data);
            end else begin
                if (m_data !== screen_cmds_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", screen_cmds_q[0], m_data);
                end
                void'(screen_cmds_q.pop_front());
            end
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (quiet || !aresetn) m_ready <= aresetn;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else m_ready <= 1'b1;
    end

    int cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_vt52_terminal_screen_engine: errors");
            $finish;
        end
    end

    task automatic test_printable();
        send_str("Hi");
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_str("\033[7mX\033[0m");
        send_item(1'b0, 8'd7);
        send_item(1'b0, 8'd9);
        send_item(1'b0, 8'd8);
        send_item(1'b0, 8'd127);
    endtask

    task automatic test_cursor_escapes();
        send_str("\033Y\x37\x6f\033Y\xff\x10Z");
        send_str("\033A\033B\033C\033D\0337\033H\0338\033Q\033[99;300H\033[5A");
        send_str("\033[300B\033[C\033[9D\033[2;3f\033[s\033[H\033[u\033[1;2;3;4;5;6z");
    endtask

    task automatic test_erase_scroll();
        send_str("\033[5;8r\033[5H\033I\033[8H\n\n\033[9;3r\033[9H\033I\n");
        send_str("\033[r\033[12;40H\033K\033J\033[K\033[J\033[2J\033E\f\r\v");
        send_str("\033[24H\n\033[?25h");
    endtask

    task automatic test_blink(logic [15:0] p, int ticks);
        write_period(p);
        t_elapsed = t_elapsed;
        repeat (ticks) send_item(1'b1, 8'($urandom));
    endtask

    task automatic test_random(int n);
        string pat [8];
        pat = '{"\033[", "\033Y", "\033", ";", "\r\n", "\033[7m", "\033[0m", "\033["};
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1: send_item(1'b0, 8'($urandom_range(32, 126)));
                2: send_item(1'b0, 8'($urandom));
                3: send_item(1'b1, 8'($urandom));
                4: send_item(1'b0, 8'($urandom_range(0, 31)));
                5: begin
                    send_str("\033[");
                    send_item(1'b0, 8'($urandom_range("0", "9")));
                    send_item(1'b0, ";");
                    send_item(1'b0, 8'($urandom_range("0", "9")));
                    send_item(1'b0, 8'("ABCDHJKfrmsu" >> (8 * $urandom_range(0, 11))));
                end
                6: begin
                    send_str("\033Y");
                    send_item(1'b0, 8'($urandom_range(30, 60)));
                    send_item(1'b0, 8'($urandom_range(30, 130)));
                end
                7: send_item(1'b0, 8'("ABCDHIJK78" >> (8 * $urandom_range(0, 9))));
                default: send_str(pat[$urandom_range(0, 7)]);
            endcase
        end
    endtask

    initial begin
        t_period = 500; t_col = 0; t_row = 0; t_scol = 0; t_srow = 0;
        t_top = 0; t_bot = ROWS - 1; t_rev = 0; t_vis = 0; t_elapsed = 0;
        t_mode = vt52s_pkg::MODE_IDLE; t_prow = 0; t_pidx = 0;
        for (int i = 0; i < 4; i++) t_par[i] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_printable();
        test_cursor_escapes();
        test_erase_scroll();
        test_blink(16'd1, 6);
        test_blink(16'hFFFF, 4);
        test_blink(16'd0, 3);
        test_blink(16'd3, 7);
        test_random(20);
        drain();
        test_random(20);
        quiet = 1'b1;
        test_random(10);
        drain();
        $display("sent %0d items, checked %0d command beats", items_sent, beats_seen);
        $display("covered escapes, CSI, scrolling, erases and blink periods 0..65535");
        if (mismatches == 0) $display("tb_vt52_terminal_screen_engine: clean");
        else $display("tb_vt52_terminal_screen_engine: errors");
        $finish;
    end
endmodule
